// ----- rtl/csem_pkg.sv -----
// Shared types and constants for the counting semaphore block.
`default_nettype none
package csem_pkg;
	localparam int SLOTS = 16;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int FILL_W = $clog2(SLOTS + 1);
	localparam logic signed [15:0] COUNT_MAX = 16'sd32767;

	typedef enum logic [1:0] {
		OP_WAIT = 2'd0,
		OP_SIGNAL = 2'd1,
		OP_TICK = 2'd2,
		OP_READ = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		K_GRANTED = 3'd0,
		K_BLOCKED = 3'd1,
		K_WOKEN = 3'd2,
		K_SIGDONE = 3'd3,
		K_READ = 3'd4,
		K_REJECTED = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SIG,
		ST_SHIFT,
		ST_TICK,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] thread;
		logic timed_out;
		logic [15:0] reply;
		logic last;
	} result_t;
endpackage
`default_nettype wire

// ----- rtl/csem_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module csem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/counting_semaphore_with_timeouts.sv -----
// Counting semaphore with FIFO and timed waiter stores; top level.
// Wait and read: the result is valid the cycle after the input transfer; input is ready once it is taken.
// Signal of n: one step per unit of n (one for n = 0), each releasing at most one thread, then the done
// result; a timed release shifts the timed list down by one entry. Tick: each timed entry is read
// and either kept with one tick less or woken as timed out. One item at a time; output stalls hold it.
// Reset loads the count with zero and empties both stores.
`default_nettype none
module counting_semaphore_with_timeouts (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tuser, // operation[1:0], zero fill
	input wire logic [31:0] s_tdata, // thread_id[7:0], timeout_ticks[23:8], release_count[31:24]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [7:0] m_tuser, // kind[2:0], timed_out[3], zero fill
	output logic [23:0] m_tdata, // woken_thread[7:0], reply_value[23:8]
	output logic m_tlast,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata
);
	import csem_pkg::*;

	state_t state_q, state_d;
	logic signed [15:0] count_q;
	logic [IDX_W-1:0] fhead_q;
	logic [FILL_W-1:0] ffill_q, tfill_q;
	logic signed [7:0] n_q;
	logic [7:0] steps_q;
	logic [7:0] released_q;
	logic [FILL_W-1:0] i_q, j_q;
	logic phase_q;
	result_t res_q;
	logic more_q;

	logic tid_we, tk_we;
	logic [IDX_W-1:0] t_waddr, t_raddr;
	logic [7:0] tid_wdata, tid_rdata;
	logic [15:0] tk_wdata, tk_rdata;
	logic fid_we;
	logic [IDX_W-1:0] fid_waddr;
	logic [7:0] fid_rdata;

	logic [7:0] tid;
	logic [15:0] tmo;
	logic signed [7:0] nin;
	logic accept;
	logic signed [15:0] cnt_inc;
	logic [IDX_W-1:0] ftail;
	logic [FILL_W:0] fsum;

	assign tid = s_tdata[7:0];
	assign tmo = s_tdata[23:8];
	assign nin = s_tdata[31:24];
	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE) && !m_tvalid;
	assign cnt_inc = (count_q < COUNT_MAX) ? count_q + 16'sd1 : count_q;
	assign fsum = {1'b0, ffill_q} + {1'b0, fhead_q};
	assign ftail = (fsum >= (FILL_W + 1)'(SLOTS)) ?
		IDX_W'(fsum - (FILL_W + 1)'(SLOTS)) : IDX_W'(fsum);

	csem_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_fid (
		.clk(clk), .we(fid_we), .waddr(fid_waddr), .wdata(tid),
		.raddr(fhead_q), .rdata(fid_rdata));
	csem_ram #(.WIDTH(8), .DEPTH(SLOTS)) u_tid (
		.clk(clk), .we(tid_we), .waddr(t_waddr), .wdata(tid_wdata),
		.raddr(t_raddr), .rdata(tid_rdata));
	csem_ram #(.WIDTH(16), .DEPTH(SLOTS)) u_tk (
		.clk(clk), .we(tk_we), .waddr(t_waddr), .wdata(tk_wdata),
		.raddr(t_raddr), .rdata(tk_rdata));

	logic wait_blocks;
	logic full;
	logic [15:0] left;
	assign wait_blocks = (count_q - 16'sd1) < 16'sd0;
	assign full = ({1'b0, ffill_q} + {1'b0, tfill_q}) >= (FILL_W + 1)'(SLOTS);
	assign left = (tk_rdata == 16'd0) ? 16'd0 : tk_rdata - 16'd1;

	always_comb begin
		fid_we = accept && (op_t'(s_tuser[1:0]) == OP_WAIT) && wait_blocks && !full
			&& (tmo == 16'd0);
		fid_waddr = ftail;
		tid_we = 1'b0;
		tk_we = 1'b0;
		t_waddr = IDX_W'(tfill_q);
		tid_wdata = tid;
		tk_wdata = tmo;
		t_raddr = IDX_W'(i_q);
		if (accept && (op_t'(s_tuser[1:0]) == OP_WAIT) && wait_blocks && !full
			&& (tmo != 16'd0)) begin
			tid_we = 1'b1;
			tk_we = 1'b1;
		end else if (state_q == ST_SHIFT && phase_q && i_q != '0) begin
			tid_we = 1'b1;
			tk_we = 1'b1;
			t_waddr = IDX_W'(i_q - 1'b1);
			tid_wdata = tid_rdata;
			tk_wdata = tk_rdata;
		end else if (state_q == ST_TICK && phase_q && left != 16'd0) begin
			tid_we = 1'b1;
			tk_we = 1'b1;
			t_waddr = IDX_W'(j_q);
			tid_wdata = tid_rdata;
			tk_wdata = left;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && op_t'(s_tuser[1:0]) == OP_SIGNAL && nin >= 0) begin
					state_d = ST_SIG;
				end else if (accept && op_t'(s_tuser[1:0]) == OP_TICK) begin
					state_d = ST_TICK;
				end
			end
			ST_SIG: begin
				if (m_tvalid) begin
					state_d = ST_SIG;
				end else if (steps_q == 8'd0) begin
					state_d = ST_IDLE;
				end else if (cnt_inc <= 0 && ffill_q == '0 && tfill_q != '0) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (i_q >= tfill_q && !m_tvalid) begin
					state_d = ST_SIG;
				end
			end
			ST_TICK: begin
				if (!m_tvalid && !phase_q && i_q >= tfill_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			fhead_q <= '0;
			ffill_q <= '0;
			tfill_q <= '0;
			m_tvalid <= 1'b0;
			phase_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			steps_q <= '0;
			released_q <= '0;
			n_q <= '0;
			res_q <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			if (cfg_we) begin
				count_q <= 16'(cfg_wdata);
				fhead_q <= '0;
				ffill_q <= '0;
				tfill_q <= '0;
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (accept) begin
							case (op_t'(s_tuser[1:0]))
								OP_WAIT: begin
									m_tvalid <= 1'b1;
									if (!wait_blocks) begin
										count_q <= count_q - 16'sd1;
										res_q <= '{K_GRANTED, tid, 1'b0, 16'd0, 1'b1};
									end else if (full) begin
										res_q <= '{K_REJECTED, tid, 1'b0, 16'd0, 1'b1};
									end else begin
										count_q <= count_q - 16'sd1;
										res_q <= '{K_BLOCKED, tid, 1'b0, 16'd0, 1'b1};
										if (tmo == 16'd0) begin
											ffill_q <= ffill_q + 1'b1;
										end else begin
											tfill_q <= tfill_q + 1'b1;
										end
									end
								end
								OP_SIGNAL: begin
									if (nin < 0) begin
										m_tvalid <= 1'b1;
										res_q <= '{K_SIGDONE, 8'd0, 1'b0, 16'(nin), 1'b1};
									end else begin
										n_q <= nin;
										steps_q <= (nin == 0) ? 8'd1 : nin;
										released_q <= '0;
									end
								end
								OP_TICK: begin
									i_q <= '0;
									j_q <= '0;
									phase_q <= 1'b0;
								end
								default: begin
									m_tvalid <= 1'b1;
									res_q <= '{K_READ, 8'd0, 1'b0, count_q, 1'b1};
								end
							endcase
						end
					end
					ST_SIG: begin
						if (!m_tvalid) begin
							if (steps_q == 8'd0) begin
								m_tvalid <= 1'b1;
								res_q <= '{K_SIGDONE, 8'd0, 1'b0,
									(n_q == 0) ? 16'd0 : 16'(released_q), 1'b1};
							end else begin
								steps_q <= steps_q - 8'd1;
								count_q <= cnt_inc;
								if (cnt_inc <= 0 && ffill_q != '0) begin
									m_tvalid <= 1'b1;
									res_q <= '{K_WOKEN, fid_rdata, 1'b0, 16'd0, 1'b0};
									released_q <= released_q + 8'd1;
									fhead_q <= fhead_q + 1'b1;
									ffill_q <= ffill_q - 1'b1;
								end else if (cnt_inc <= 0 && tfill_q != '0) begin
									released_q <= released_q + 8'd1;
									i_q <= '0;
									phase_q <= 1'b0;
								end
							end
						end
					end
					ST_SHIFT: begin
						if (i_q < tfill_q) begin
							if (!phase_q) begin
								phase_q <= 1'b1;
							end else begin
								phase_q <= 1'b0;
								if (i_q == '0) begin
									m_tvalid <= 1'b1;
									res_q <= '{K_WOKEN, tid_rdata, 1'b0, 16'd0, 1'b0};
								end
								i_q <= i_q + 1'b1;
							end
						end else if (!m_tvalid) begin
							tfill_q <= tfill_q - 1'b1;
						end
					end
					ST_TICK: begin
						if (!m_tvalid) begin
							if (!phase_q) begin
								if (i_q >= tfill_q) begin
									tfill_q <= j_q;
									if (more_q) begin
										m_tvalid <= 1'b1;
										res_q.last <= 1'b1;
									end
								end else begin
									phase_q <= 1'b1;
								end
							end else begin
								if (left != 16'd0) begin
									phase_q <= 1'b0;
									i_q <= i_q + 1'b1;
									j_q <= j_q + 1'b1;
								end else if (more_q) begin
									m_tvalid <= 1'b1;
								end else begin
									phase_q <= 1'b0;
									i_q <= i_q + 1'b1;
									count_q <= cnt_inc;
									res_q <= '{K_WOKEN, tid_rdata, 1'b1, 16'd0, 1'b0};
								end
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// Track a held timed-out wake that is sent once the next one is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			more_q <= 1'b0;
		end else if (state_q == ST_IDLE) begin
			more_q <= 1'b0;
		end else if (state_q == ST_TICK && !m_tvalid && phase_q && left == 16'd0) begin
			more_q <= !more_q;
		end else if (state_q == ST_TICK && !m_tvalid && !phase_q && i_q >= tfill_q) begin
			more_q <= 1'b0;
		end
	end

	assign m_tuser = {4'd0, res_q.timed_out, res_q.kind};
	assign m_tdata = {res_q.reply, res_q.thread};
	assign m_tlast = res_q.last;
endmodule
`default_nettype wire

// ----- sim/semaphore_checker.sv -----
// Checker for the counting semaphore: watches both streams, predicts results and compares.
`timescale 1ns / 1ps
module semaphore_checker
	import csem_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [7:0] s_tuser,
	input wire logic [31:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [7:0] m_tuser,
	input wire logic [23:0] m_tdata,
	input wire logic m_tlast,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	output int errors,
	output int pending,
	output int results_seen
);
	typedef struct {
		kind_t kind;
		logic [7:0] thr;
		logic to;
		logic [15:0] reply;
		logic last;
	} sem_result_t;

	typedef struct {
		logic [7:0] id;
		logic [15:0] ticks;
	} timed_waiter_t;

	sem_result_t results_due[$];
	sem_result_t fresh[$];
	logic [7:0] forever_q[$];
	timed_waiter_t timed_q[$];
	int sem_cnt;

	function automatic void add(kind_t k, logic [7:0] t, logic to, logic [15:0] r);
		sem_result_t e;
		e.kind = k;
		e.thr = t;
		e.to = to;
		e.reply = r;
		e.last = 1'b0;
		fresh.push_back(e);
	endfunction

	function automatic void bump();
		if (sem_cnt < 32767)
			sem_cnt++;
	endfunction

	function automatic void predict(op_t op, logic [7:0] tid, logic [15:0] tmo,
			logic signed [7:0] nb);
		int n;
		int steps;
		int released;
		timed_waiter_t tw;
		timed_waiter_t keep[$];
		n = nb;
		fresh.delete();
		case (op)
			OP_WAIT: begin
				if (sem_cnt - 1 < 0) begin
					if (forever_q.size() + timed_q.size() >= SLOTS) begin
						add(K_REJECTED, tid, 1'b0, 16'd0);
					end else begin
						sem_cnt--;
						if (tmo == 16'd0)
							forever_q.push_back(tid);
						else
							timed_q.push_back('{tid, tmo});
						add(K_BLOCKED, tid, 1'b0, 16'd0);
					end
				end else begin
					sem_cnt--;
					add(K_GRANTED, tid, 1'b0, 16'd0);
				end
			end
			OP_SIGNAL: begin
				if (n < 0) begin
					add(K_SIGDONE, 8'd0, 1'b0, 16'(n));
				end else begin
					steps = (n == 0) ? 1 : n;
					released = 0;
					for (int s = 0; s < steps; s++) begin
						bump();
						if (sem_cnt <= 0) begin
							if (forever_q.size() > 0) begin
								add(K_WOKEN, forever_q.pop_front(), 1'b0, 16'd0);
								released++;
							end else if (timed_q.size() > 0) begin
								tw = timed_q.pop_front();
								add(K_WOKEN, tw.id, 1'b0, 16'd0);
								released++;
							end
						end
					end
					add(K_SIGDONE, 8'd0, 1'b0, (n == 0) ? 16'd0 : 16'(released));
				end
			end
			OP_TICK: begin
				foreach (timed_q[i]) begin
					if (timed_q[i].ticks > 16'd1) begin
						keep.push_back('{timed_q[i].id, timed_q[i].ticks - 16'd1});
					end else begin
						bump();
						add(K_WOKEN, timed_q[i].id, 1'b1, 16'd0);
					end
				end
				timed_q = keep;
			end
			default: add(K_READ, 8'd0, 1'b0, 16'(sem_cnt));
		endcase
		if (fresh.size() > 0)
			fresh[fresh.size() - 1].last = 1'b1;
		foreach (fresh[i])
			results_due.push_back(fresh[i]);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sem_result_t e;
		if (!arst_n) begin
			sem_cnt = 0;
			forever_q.delete();
			timed_q.delete();
			results_due.delete();
			errors <= 0;
			pending <= 0;
			results_seen <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result kind=%0d thread=%0d to=%0b reply=%0d last=%0b",
						$time, m_tuser[2:0], m_tdata[7:0], m_tuser[3],
						$signed(m_tdata[23:8]), m_tlast);
					errors <= errors + 1;
				end else begin
					e = results_due.pop_front();
					if (m_tuser[2:0] !== e.kind || m_tdata[7:0] !== e.thr ||
							m_tuser[3] !== e.to || m_tdata[23:8] !== e.reply ||
							m_tlast !== e.last) begin
						$display("%0t: mismatch expected kind=%0d thread=%0d to=%0b reply=%0d last=%0b",
							$time, e.kind, e.thr, e.to, $signed(e.reply), e.last);
						$display("%0t:          actual   kind=%0d thread=%0d to=%0b reply=%0d last=%0b",
							$time, m_tuser[2:0], m_tdata[7:0], m_tuser[3],
							$signed(m_tdata[23:8]), m_tlast);
						errors <= errors + 1;
					end
				end
			end
			if (cfg_we) begin
				sem_cnt = cfg_wdata;
				forever_q.delete();
				timed_q.delete();
			end
			if (s_tvalid && s_tready)
				predict(op_t'(s_tuser[1:0]), s_tdata[7:0], s_tdata[23:8], s_tdata[31:24]);
			pending <= results_due.size();
		end
	end
endmodule

// ----- sim/testbench.sv -----
// Testbench top for the counting semaphore: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module testbench;
	import csem_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tuser = '0;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tuser;
	logic [23:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_wdata = '0;
	int errors;
	int pending;
	int results_seen;
	int send_idle = 0;
	int recv_stall = 0;
	int items_sent = 0;
	int hold_cnt = 0;
	logic hold_go = 1'b0;
	logic hold_used = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	counting_semaphore_with_timeouts dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	semaphore_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending), .results_seen(results_seen)
	);

	// hold off the output once for a long stretch, else stall at random
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1'b1;
			hold_cnt <= 600;
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall);
		end
	end

	task automatic send(op_t op, logic [7:0] tid, logic [15:0] tmo, logic signed [7:0] n);
		logic rdy;
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {6'd0, op};
		s_tdata <= {n, tmo, tid};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		items_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic load_count(logic [7:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_item();
		int r;
		logic [15:0] tmo;
		logic signed [7:0] n;
		r = $urandom_range(99);
		tmo = ($urandom_range(1)) ? 16'd0 : 16'($urandom_range(1, 5));
		if ($urandom_range(9) == 0)
			tmo = 16'($urandom);
		n = 8'($urandom_range(0, 4));
		if ($urandom_range(9) == 0)
			n = 8'($urandom);
		if (r < 40)
			send(OP_WAIT, 8'($urandom), tmo, 8'($urandom));
		else if (r < 65)
			send(OP_SIGNAL, 8'($urandom), 16'($urandom), n);
		else if (r < 90)
			send(OP_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
		else
			send(OP_READ, 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	initial begin
		#600000000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_READ, 8'h00, 16'h0000, 8'sh00);
		send(OP_TICK, 8'h00, 16'h0000, 8'sh00);
		send(OP_WAIT, 8'h00, 16'h0000, 8'sh00);
		send(OP_WAIT, 8'hFF, 16'hFFFF, 8'sh7F);
		send(OP_WAIT, 8'hAA, 16'h0001, 8'sh80);
		send(OP_WAIT, 8'h55, 16'h0002, 8'sh00);
		send(OP_TICK, 8'h00, 16'h0000, 8'sh00);
		send(OP_READ, 8'h00, 16'h0000, 8'sh00);
		send(OP_SIGNAL, 8'h00, 16'h0000, 8'sh00);
		send(OP_SIGNAL, 8'h00, 16'h0000, -8'sd128);
		send(OP_SIGNAL, 8'h00, 16'h0000, -8'sd1);
		send(OP_SIGNAL, 8'h00, 16'h0000, 8'sd127);
		send(OP_READ, 8'h00, 16'h0000, 8'sh00);
		for (int i = 0; i < 17; i++)
			send(OP_WAIT, 8'(i * 15), (i % 2) ? 16'(i) : 16'd0, 8'sh00);
		send(OP_SIGNAL, 8'h00, 16'h0000, 8'sd20);

		load_count(8'd0);
		hold_go <= 1'b1;
		for (int i = 0; i < 30; i++)
			send(OP_WAIT, 8'($urandom), 16'($urandom_range(0, 3)), 8'sh00);
		send(OP_SIGNAL, 8'h00, 16'h0000, 8'sd127);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin load_count(8'd0); send_idle = 0; recv_stall = 0; end
				1: begin load_count(8'd255); send_idle = 76; recv_stall = 0; end
				2: begin load_count(8'd1); send_idle = 0; recv_stall = 76; end
				default: begin load_count(8'($urandom_range(0, 3))); send_idle = 23;
					recv_stall = 23; end
			endcase
			for (int i = 0; i < 50; i++)
				random_item();
		end

		drain();
		$display("Sent %0d items and checked %0d results over four idling phases,",
			items_sent, results_seen);
		$display("with full store, timeouts, negative and zero signals and backpressure.");
		if (errors == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
